// ===== rtl/b64c_pkg.sv =====
// Shared types, constants and alphabet functions of the base64 stream codec.
`default_nettype none
package b64c_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 4;
  localparam int unsigned LIMIT_W = 12;
  localparam logic [7:0] PAD_CHAR = 8'h3D;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 12'hFFF;
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  typedef enum logic [0:0] {
    REG_DIRECTION    = 1'b0,
    REG_OUTPUT_LIMIT = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic               direction;
    logic [LIMIT_W-1:0] output_limit;
  } cfg_t;

  // One queue entry: the result words caused by one accepted input word.
  typedef struct packed {
    logic [3:0][7:0] chars;
    logic [1:0]      last_idx;
    logic            data;
    logic            msg_end;
  } job_t;

  typedef struct packed {
    logic       ok;
    logic [5:0] val;
  } cval_t;

  function automatic cval_t char_value(input logic [7:0] c);
    cval_t r;
    r = '0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r.ok  = 1'b1;
      r.val = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r.ok  = 1'b1;
      r.val = 6'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r.ok  = 1'b1;
      r.val = 6'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B) begin
      r.ok  = 1'b1;
      r.val = 6'd62;
    end else if (c == 8'h2F) begin
      r.ok  = 1'b1;
      r.val = 6'd63;
    end
    return r;
  endfunction

  function automatic logic [7:0] enc_char(input logic [5:0] v);
    logic [7:0] r;
    if (v < 6'd26) begin
      r = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      r = 8'h61 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      r = 8'h30 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      r = 8'h2B;
    end else begin
      r = 8'h2F;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/b64c_item_if.sv =====
// Input channel interface: one character or data byte per word.
`default_nettype none
interface b64c_item_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       message_last;

  modport source(output valid, output in_byte, output message_last, input ready);
  modport sink(input valid, input in_byte, input message_last, output ready);
endinterface
`default_nettype wire

// ===== rtl/b64c_result_if.sv =====
// Output channel interface: one decoded byte, character or end marker per word.
`default_nettype none
interface b64c_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_valid;
  logic       run_last;
  logic       message_end;

  modport source(output valid, output out_byte, output out_valid, output run_last,
                 output message_end, input ready);
  modport sink(input valid, input out_byte, input out_valid, input run_last,
               input message_end, output ready);
endinterface
`default_nettype wire

// ===== rtl/base64_stream_codec_top.sv =====
// The job of an accepted input word is written to the queue; its result words then go out through the output register.
// Input words are taken one per cycle while the job queue has room (QUEUE_DEPTH jobs).
// Result words leave at one per cycle while the sink is ready: decode sustains one input word per
// cycle, and encode emits four result words per group of three input words, set by the single-word output register.
// Reset (rst, synchronous) empties the queue, clears all message state, and sets
// direction to 0 and output_limit to 4095.
`default_nettype none
module base64_stream_codec_top #(
  parameter int unsigned QUEUE_DEPTH = b64c_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [b64c_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [b64c_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [b64c_pkg::APB_DATA_W-1:0] prdata,
  output logic                               pready,
  b64c_item_if.sink                          item,
  b64c_result_if.source                      result
);
  import b64c_pkg::*;

  cfg_t cfg;
  logic wr_en;
  job_t fj, qj;
  logic push, q_full, q_valid, pop;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[1:0] == 2'b00);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.direction    <= 1'b0;
      cfg.output_limit <= LIMIT_RESET;
    end else if (wr_en) begin
      unique case (reg_idx_t'(paddr[2]))
        REG_DIRECTION:    cfg.direction    <= pwdata[0];
        REG_OUTPUT_LIMIT: cfg.output_limit <= pwdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx_t'(paddr[2]))
      REG_DIRECTION:    prdata = {{(APB_DATA_W-1){1'b0}}, cfg.direction};
      REG_OUTPUT_LIMIT: prdata = {{(APB_DATA_W-LIMIT_W){1'b0}}, cfg.output_limit};
      default:          prdata = '0;
    endcase
  end

  b64c_front u_front (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .item   (item),
    .q_full (q_full),
    .push   (push),
    .job    (fj)
  );

  b64c_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_job   (fj),
    .full     (q_full),
    .pop      (pop),
    .rd_valid (q_valid),
    .rd_job   (qj)
  );

  b64c_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_job   (qj),
    .pop     (pop),
    .result  (result)
  );

endmodule
`default_nettype wire

// ===== rtl/b64c_front.sv =====
// Front end: accepts input words, runs the codec state and builds result jobs.
`default_nettype none
module b64c_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire b64c_pkg::cfg_t cfg,
  b64c_item_if.sink          item,
  input  wire logic          q_full,
  output logic               push,
  output b64c_pkg::job_t     job
);
  import b64c_pkg::*;

  logic [11:0]        acc, acc_next;
  logic [2:0]         pend, pend_next;
  logic               pad, pad_next;
  logic [LIMIT_W-1:0] cnt, cnt_next;
  logic [15:0]        grp, grp_next;
  logic [1:0]         fill, fill_next;
  logic               lim, lim_next;
  logic               accept;

  assign item.ready = !q_full;
  assign accept     = item.valid && !q_full;

  always_comb begin
    cval_t       cv;
    logic [3:0]  psum;
    logic [3:0]  pnew;
    logic [11:0] shifted;
    logic [2:0]  fill_sum;
    logic [23:0] word;
    logic [23:0] gv;
    logic [2:0]  nfill;
    logic        emit;
    logic [2:0]  nres;
    logic [7:0]  c;

    c         = item.in_byte;
    cv        = char_value(c);
    psum      = {1'b0, pend} + 4'd6;
    pnew      = psum;
    shifted   = '0;
    fill_sum  = {1'b0, fill} + 3'd1;
    word      = {grp, c};
    gv        = word;
    nfill     = 3'd3;
    emit      = 1'b0;
    nres      = 3'd0;
    acc_next  = acc;
    pend_next = pend;
    pad_next  = pad;
    cnt_next  = cnt;
    grp_next  = grp;
    fill_next = fill;
    lim_next  = lim;
    job       = '0;

    if (!cfg.direction) begin
      if (!pad) begin
        if (c == PAD_CHAR) begin
          pad_next = 1'b1;
        end else if (cv.ok) begin
          acc_next = {acc[5:0], cv.val};
          if (psum >= 4'd8) begin
            pnew = psum - 4'd8;
            if (cnt < cfg.output_limit) begin
              shifted      = acc_next >> pnew;
              job.chars[0] = shifted[7:0];
              nres         = 3'd1;
              cnt_next     = cnt + 1'b1;
            end
          end
          pend_next = pnew[2:0];
        end
      end
    end else begin
      if (fill_sum >= 3'd3) begin
        emit      = 1'b1;
        grp_next  = '0;
        fill_next = '0;
      end else if (item.message_last) begin
        emit  = 1'b1;
        nfill = fill_sum;
        gv    = (fill_sum == 3'd1) ? {c, 16'h0000} : {grp[7:0], c, 8'h00};
      end else begin
        grp_next  = word[15:0];
        fill_next = fill_sum[1:0];
      end
      if (emit) begin
        if (lim || ({1'b0, cnt} + 13'd4 >= {1'b0, cfg.output_limit})) begin
          lim_next = 1'b1;
        end else begin
          job.chars[0] = enc_char(gv[23:18]);
          job.chars[1] = enc_char(gv[17:12]);
          job.chars[2] = (nfill >= 3'd2) ? enc_char(gv[11:6]) : PAD_CHAR;
          job.chars[3] = (nfill >= 3'd3) ? enc_char(gv[5:0]) : PAD_CHAR;
          nres         = 3'd4;
          cnt_next     = cnt + 12'd4;
        end
      end
    end

    // A closing word with nothing to show still gets a bare end marker.
    job.data = 1'b1;
    if (item.message_last && nres == 3'd0) begin
      job.data = 1'b0;
      nres     = 3'd1;
    end
    job.last_idx = 2'(nres - 3'd1);
    job.msg_end  = item.message_last;
    push         = accept && (nres != 3'd0);

    if (item.message_last) begin
      acc_next  = '0;
      pend_next = '0;
      pad_next  = 1'b0;
      cnt_next  = '0;
      grp_next  = '0;
      fill_next = '0;
      lim_next  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc  <= '0;
      pend <= '0;
      pad  <= 1'b0;
      cnt  <= '0;
      grp  <= '0;
      fill <= '0;
      lim  <= 1'b0;
    end else if (accept) begin
      acc  <= acc_next;
      pend <= pend_next;
      pad  <= pad_next;
      cnt  <= cnt_next;
      grp  <= grp_next;
      fill <= fill_next;
      lim  <= lim_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/b64c_queue.sv =====
// Job queue between the front end and the output sequencer.
`default_nettype none
module b64c_queue #(
  parameter int unsigned DEPTH = b64c_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire b64c_pkg::job_t wr_job,
  output logic                full,
  input  wire logic           pop,
  output logic                rd_valid,
  output b64c_pkg::job_t      rd_job
);
  import b64c_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  job_t          entries [DEPTH];
  logic [PW-1:0] wptr, rptr;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign full     = (count == CW'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_job   = entries[rptr];
  assign do_push  = push && !full;
  assign do_pop   = pop && rd_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + CW'(do_push) - CW'(do_pop);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/b64c_back.sv =====
// Output sequencer: plays each queued job out as result words, one per cycle while the sink is ready.
`default_nettype none
module b64c_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           q_valid,
  input  wire b64c_pkg::job_t q_job,
  output logic                pop,
  b64c_result_if.source       result
);
  import b64c_pkg::*;

  logic [1:0] idx;
  logic       load;
  logic       at_end;

  assign load   = q_valid && (!result.valid || result.ready);
  assign at_end = (idx == q_job.last_idx);
  assign pop    = load && at_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
      idx          <= '0;
    end else begin
      if (load) begin
        result.valid <= 1'b1;
        idx          <= at_end ? 2'd0 : idx + 2'd1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.out_byte    <= q_job.chars[idx];
      result.out_valid   <= q_job.data;
      result.run_last    <= at_end;
      result.message_end <= at_end && q_job.msg_end;
    end
  end

  a_end_is_run_last: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.message_end |-> result.run_last)
    else $error("message end without run end");

  a_marker_form: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.out_valid |->
      result.run_last && result.message_end && result.out_byte == 8'h00)
    else $error("malformed end marker");

  a_mid_job_held: assert property (@(posedge clk) disable iff (rst)
    idx != 2'd0 |-> q_valid)
    else $error("job left the queue before all its words were sent");

  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    q_valid && idx != 2'd0 |-> idx <= q_job.last_idx)
    else $error("word index ran past the job");

endmodule
`default_nettype wire

// ===== tb/tb_base64_stream_codec_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the base64 stream codec: directed and random messages, both directions.
module tb_base64_stream_codec_top;
  import b64c_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int SETTLE_CYCLES = 10;
  localparam int PHASE_WORDS = 145;

  typedef logic [7:0] byte_q_t[$];

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       run_last;
    logic       message_end;
  } codec_word_t;

  // Keeps its own copy of the codec state and registers and checks each result word.
  class codec_scoreboard;
    string       alpha_set;
    int          decode_tab[256];
    logic        direction;
    logic [11:0] output_limit;
    logic [11:0] bit_acc;
    logic [3:0]  pend_bits;
    logic        pad_seen;
    logic [11:0] emitted;
    logic [15:0] group_bytes;
    logic [1:0]  group_fill;
    logic        limit_hit;
    codec_word_t expected_words[$];
    int          errors;

    function new();
      alpha_set = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
      for (int i = 0; i < 256; i++) decode_tab[i] = -1;
      for (int i = 0; i < 64; i++) decode_tab[alpha_set[i]] = i;
      direction = 1'b0;
      output_limit = LIMIT_RESET;
      errors = 0;
      clear_message();
    endfunction

    function void clear_message();
      bit_acc = '0;
      pend_bits = '0;
      pad_seen = 1'b0;
      emitted = '0;
      group_bytes = '0;
      group_fill = '0;
      limit_hit = 1'b0;
    endfunction

    function void set_register(reg_idx_t idx, logic [31:0] value);
      case (idx)
        REG_DIRECTION: direction = value[0];
        REG_OUTPUT_LIMIT: output_limit = value[11:0];
        default: ;
      endcase
    endfunction

    function codec_word_t data_word(logic [7:0] b);
      return {b, 3'b100};
    endfunction

    // One group of four characters; nfilled counts the real bytes in it.
    function void emit_group(ref codec_word_t outs[$], input logic [23:0] v, input int nfilled);
      if (limit_hit || ({1'b0, emitted} + 13'd4 >= {1'b0, output_limit})) begin
        limit_hit = 1'b1;
        return;
      end
      outs.push_back(data_word(alpha_set[v[23:18]]));
      outs.push_back(data_word(alpha_set[v[17:12]]));
      outs.push_back(data_word(nfilled >= 2 ? alpha_set[v[11:6]] : PAD_CHAR));
      outs.push_back(data_word(nfilled >= 3 ? alpha_set[v[5:0]] : PAD_CHAR));
      emitted = emitted + 12'd4;
    endfunction

    function void predict_word(logic [7:0] c, logic last);
      codec_word_t outs[$];
      logic [23:0] grp;
      logic [1:0]  fill;
      int          sixbits;
      int          n;
      if (!direction) begin
        if (!pad_seen) begin
          if (c == PAD_CHAR) begin
            pad_seen = 1'b1;
          end else begin
            sixbits = decode_tab[c];
            if (sixbits >= 0) begin
              bit_acc = {bit_acc[5:0], sixbits[5:0]};
              pend_bits = pend_bits + 4'd6;
              if (pend_bits >= 4'd8) begin
                pend_bits = pend_bits - 4'd8;
                if (emitted < output_limit) begin
                  outs.push_back(data_word(8'(bit_acc >> pend_bits)));
                  emitted = emitted + 12'd1;
                end
              end
            end
          end
        end
      end else begin
        fill = group_fill + 2'd1;
        grp = {group_bytes, c};
        if (fill == 2'd3) begin
          emit_group(outs, grp, 3);
          group_bytes = '0;
          group_fill = '0;
        end else if (last) begin
          // A partial group is left-aligned before the padding is added.
          if (fill == 2'd1) grp = {c, 16'h0000};
          else grp = {group_bytes[7:0], c, 8'h00};
          emit_group(outs, grp, int'(fill));
        end else begin
          group_bytes = grp[15:0];
          group_fill = fill;
        end
      end
      if (last && outs.size() == 0) outs.push_back('0);
      n = outs.size();
      if (n > 0) begin
        outs[n-1].run_last = 1'b1;
        outs[n-1].message_end = last;
      end
      foreach (outs[i]) expected_words.push_back(outs[i]);
      if (last) clear_message();
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_word(codec_word_t got);
      codec_word_t want;
      if (expected_words.size() == 0) begin
        $display("%0t ns: result word %h arrived with nothing expected, expected none, got %h",
                 $time, got, got);
        errors++;
        return;
      end
      want = expected_words.pop_front();
      if ($isunknown(got)) begin
        $display("%0t ns: unknown bits in result, expected %h, got %h", $time, want, got);
        errors++;
        return;
      end
      compare_field("out_byte", want.out_byte, got.out_byte);
      compare_field("out_valid", want.out_valid, got.out_valid);
      compare_field("run_last", want.run_last, got.run_last);
      compare_field("message_end", want.message_end, got.message_end);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  b64c_item_if   item_bus ();
  b64c_result_if result_bus ();

  base64_stream_codec_top dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .item    (item_bus),
    .result  (result_bus)
  );

  codec_scoreboard board = new();
  int src_idle_pct;
  int sink_idle_pct;
  int words_sent;
  int words_in;
  int words_out;
  int messages_done;
  int config_writes;
  int idle_cycles;

  always #6 clk = ~clk;

  always @(posedge clk) begin
    result_bus.ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (item_bus.valid && item_bus.ready) begin
        board.predict_word(item_bus.in_byte, item_bus.message_last);
        words_in++;
        if (item_bus.message_last) messages_done++;
      end
      if (result_bus.valid && result_bus.ready) begin
        board.check_word({result_bus.out_byte, result_bus.out_valid, result_bus.run_last,
                          result_bus.message_end});
        words_out++;
      end
    end
  end

  // Ends a hung run: counts cycles in which no word and no register access moves.
  always @(posedge clk) begin
    if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready) || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ns: watchdog expired with %0d result words outstanding", $time,
               board.expected_words.size());
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_word(input logic [7:0] c, input logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      item_bus.valid <= 1'b0;
      @(posedge clk);
    end
    item_bus.valid <= 1'b1;
    item_bus.in_byte <= c;
    item_bus.message_last <= last;
    do @(posedge clk); while (!item_bus.ready);
    words_sent++;
  endtask

  task automatic send_text(input string s, input logic ends);
    for (int i = 0; i < s.len(); i++) send_word(s[i], ends && (i == s.len() - 1));
  endtask

  // Holds the input until every expected word is out, then lets word-less jobs clear.
  task automatic drain_results();
    item_bus.valid <= 1'b0;
    do @(posedge clk); while (board.expected_words.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input reg_idx_t idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= APB_ADDR_W'(4 * int'(idx));
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    board.set_register(idx, value);
    config_writes++;
    @(posedge clk);
  endtask

  task automatic send_message(input byte_q_t body, input int flip_at);
    foreach (body[i]) begin
      if (i == flip_at) begin
        drain_results();
        write_register(REG_DIRECTION, {31'b0, ~board.direction});
      end
      send_word(body[i], i == body.size() - 1);
    end
  endtask

  function automatic logic [11:0] pick_limit();
    int r;
    r = $urandom_range(99);
    if (r < 5) return 12'd0;
    if (r < 30) return LIMIT_RESET;
    if (r < 70) return 12'($urandom_range(1, 24));
    return 12'($urandom_range(25, 4094));
  endfunction

  // Mostly well-formed base64 text, with stray bytes, padding and some pure noise.
  function automatic byte_q_t build_text();
    byte_q_t t;
    int      pad;
    int      n;
    if ($urandom_range(99) < 15) begin
      repeat ($urandom_range(1, 12)) t.push_back(8'($urandom_range(255)));
      return t;
    end
    repeat (4 * $urandom_range(1, 5)) begin
      if ($urandom_range(99) < 8) t.push_back(8'($urandom_range(255)));
      t.push_back(board.alpha_set[$urandom_range(63)]);
    end
    pad = $urandom_range(3);
    n = t.size();
    if (pad >= 1) t[n-1] = PAD_CHAR;
    if (pad == 2) t[n-2] = PAD_CHAR;
    // Text after the padding must be ignored.
    if ($urandom_range(99) < 10) t.push_back(board.alpha_set[$urandom_range(63)]);
    return t;
  endfunction

  function automatic byte_q_t build_data();
    byte_q_t d;
    repeat ($urandom_range(1, 14)) d.push_back(8'($urandom_range(255)));
    return d;
  endfunction

  task automatic run_random_phase(input int src_pct, input int sink_pct);
    int      stop_at;
    int      flip_at;
    byte_q_t body;
    src_idle_pct = src_pct;
    sink_idle_pct = sink_pct;
    stop_at = words_sent + PHASE_WORDS;
    while (words_sent < stop_at) begin
      if ($urandom_range(99) < 40) begin
        drain_results();
        if ($urandom_range(1) == 1) write_register(REG_DIRECTION, 32'($urandom_range(1)));
        write_register(REG_OUTPUT_LIMIT, {20'b0, pick_limit()});
      end
      body = board.direction ? build_data() : build_text();
      flip_at = -1;
      if (body.size() > 1 && $urandom_range(99) < 6) flip_at = $urandom_range(1, body.size() - 1);
      send_message(body, flip_at);
    end
  endtask

  initial begin
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    item_bus.valid <= 1'b0;
    item_bus.in_byte <= 8'h00;
    item_bus.message_last <= 1'b0;
    src_idle_pct = 19;
    sink_idle_pct = 66;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_register(REG_DIRECTION, 32'd0);
    write_register(REG_OUTPUT_LIMIT, {20'b0, LIMIT_RESET});

    // Decode: a full quantum, then skipped bytes, top alphabet values and text past a pad.
    send_text("TWFu", 1'b1);
    send_word(8'h00, 1'b0);
    send_text("+/", 1'b0);
    send_word(8'hFF, 1'b0);
    send_text("9z=Q", 1'b1);
    // A message holding only a pad ends with a bare end marker.
    send_text("=", 1'b1);

    // Encode: a full group of extreme bytes, then one- and two-byte tails.
    drain_results();
    write_register(REG_DIRECTION, 32'd1);
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'h80, 1'b1);
    send_word(8'hFF, 1'b1);
    send_word(8'h5A, 1'b0);
    send_word(8'hA5, 1'b1);

    // Zero output limit drops all result data in both directions; only end markers come out.
    drain_results();
    write_register(REG_OUTPUT_LIMIT, 32'd0);
    send_word(8'h01, 1'b1);
    drain_results();
    write_register(REG_DIRECTION, 32'd0);
    send_text("QUJD", 1'b1);
    drain_results();
    write_register(REG_OUTPUT_LIMIT, {20'b0, LIMIT_RESET});

    run_random_phase(19, 66);
    run_random_phase(66, 19);
    run_random_phase(0, 0);
    drain_results();

    $display("Run covered %0d input words in %0d messages, %0d result words, %0d register writes,",
             words_in, messages_done, words_out, config_writes);
    $display("both directions, limits from 0 to 4095, direction flips mid-message and stalls.");
    if (board.errors == 0 && board.expected_words.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/b64c_pkg.sv
rtl/b64c_item_if.sv
rtl/b64c_result_if.sv
rtl/b64c_front.sv
rtl/b64c_queue.sv
rtl/b64c_back.sv
rtl/base64_stream_codec_top.sv
tb/tb_base64_stream_codec_top.sv
